// ===== hw/rtl/idt_pkg.sv =====
`default_nettype none

package idt_pkg;

    localparam int SITE_SLOTS = 32;
    localparam int SLOT_W = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(SITE_SLOTS + 1);
    localparam int DEPTH_BITS = 16;
    localparam int WIN_W = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] ACT_EMULATED = 2'd0;
    localparam logic [1:0] ACT_PATCH_NOP = 2'd1;
    localparam logic [1:0] ACT_RESYNC = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_BUDGET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;

    localparam logic [15:0] FAULT_BUDGET_RESET = 16'd2000;
    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd1000;

    typedef struct packed {
        logic        kind;
        logic [31:0] site_address;
        logic        is_cli;
        logic [31:0] now_ms;
    } idt_in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        interrupts_disabled;
        logic        emulation_on;
        logic [15:0] depth_now;
        logic [15:0] depth_before;
        logic [5:0]  site_slot;
        logic [31:0] site_hit_count;
        logic        budget_tripped;
        logic        leak_found;
        logic [31:0] leak_total;
        logic [31:0] fault_total;
    } idt_out_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } idt_cmd_t;

    typedef struct packed {
        logic bypass;
        logic scan_done;
        logic out_free;
    } idt_status_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] depth_field(input logic [DEPTH_BITS-1:0] d);
        logic [31:0] w;
        w = 32'(d);
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/idt_ctrl.sv =====
`default_nettype none

module idt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire idt_pkg::idt_status_t status,
    output idt_pkg::idt_cmd_t         cmd
);
    import idt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.bypass)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (status.scan_done)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/idt_datapath.sv =====
`default_nettype none

module idt_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire idt_pkg::idt_cmd_t                cmd,
    output idt_pkg::idt_status_t                  status,
    input  wire idt_pkg::idt_in_t                 in_data,
    output idt_pkg::idt_out_t                     out_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    input  wire logic                             cfg_we,
    input  wire logic [idt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [idt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import idt_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [WIN_W-1:0] WIN_MAX = '1;

    logic [31:0] site_addr_mem [SITE_SLOTS];
    logic [31:0] site_hits_mem [SITE_SLOTS];

    logic [15:0] budget_reg;
    logic [15:0] win_len_reg;

    idt_in_t item_reg;

    logic [SLOT_CNT_W-1:0] fill_reg;
    logic [SLOT_CNT_W-1:0] fill_next;
    logic [SLOT_CNT_W-1:0] idx_reg;
    logic                  pend_reg;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic [31:0]           rd_addr_reg;
    logic [31:0]           rd_hits_reg;
    logic                  hit_reg;
    logic [SLOT_W-1:0]     hit_slot_reg;
    logic [31:0]           hit_cnt_reg;

    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic                  emu_reg;
    logic                  emu_next;
    logic                  begun_reg;
    logic                  begun_next;
    logic [31:0]           start_reg;
    logic [31:0]           start_next;
    logic [WIN_W-1:0]      wf_reg;
    logic [WIN_W-1:0]      wf_next;
    logic [31:0]           faults_reg;
    logic [31:0]           faults_next;
    logic [31:0]           leaks_reg;
    logic [31:0]           leaks_next;

    logic     out_valid_reg;
    idt_out_t out_reg;
    idt_out_t out_next;

    logic                  issue;
    logic                  match;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_slot;
    logic                  wr_addr_en;
    logic [31:0]           wr_hits;
    logic [31:0]           start_eff;
    logic [31:0]           elapsed;
    logic [WIN_W-1:0]      wf_inc;
    logic                  trip;

    assign issue = (idx_reg < fill_reg);
    assign match = pend_reg && (rd_addr_reg == item_reg.site_address);

    assign status.bypass = item_reg.kind || !emu_reg;
    assign status.scan_done = match || !issue;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        depth_next = depth_reg;
        emu_next = emu_reg;
        begun_next = begun_reg;
        start_next = start_reg;
        wf_next = wf_reg;
        faults_next = faults_reg;
        leaks_next = leaks_reg;
        fill_next = fill_reg;
        wr_en = 1'b0;
        wr_addr_en = 1'b0;
        wr_slot = hit_slot_reg;
        wr_hits = sat_inc32(hit_cnt_reg);
        trip = 1'b0;
        start_eff = begun_reg ? start_reg : item_reg.now_ms;
        elapsed = item_reg.now_ms - start_eff;
        wf_inc = (wf_reg == WIN_MAX) ? wf_reg : wf_reg + 1'b1;

        out_next = '0;
        out_next.depth_before = depth_field(depth_reg);
        out_next.site_slot = 6'(SITE_SLOTS);

        if (item_reg.kind)
        begin
            out_next.action = ACT_RESYNC;
            if (depth_reg != '0)
            begin
                out_next.leak_found = 1'b1;
                leaks_next = sat_inc32(leaks_reg);
            end
            depth_next = '0;
        end
        else if (!emu_reg)
        begin
            out_next.action = ACT_PATCH_NOP;
        end
        else
        begin
            out_next.action = ACT_EMULATED;
            if (hit_reg)
            begin
                wr_en = 1'b1;
                out_next.site_slot = 6'(hit_slot_reg);
                out_next.site_hit_count = wr_hits;
            end
            else if (fill_reg < SLOT_CNT_W'(SITE_SLOTS))
            begin
                wr_en = 1'b1;
                wr_addr_en = 1'b1;
                wr_slot = fill_reg[SLOT_W-1:0];
                wr_hits = 32'd1;
                fill_next = fill_reg + 1'b1;
                out_next.site_slot = 6'(fill_reg);
                out_next.site_hit_count = 32'd1;
            end

            if (item_reg.is_cli)
            begin
                if (depth_reg != DEPTH_MAX)
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            else if (depth_reg != '0)
            begin
                depth_next = depth_reg - 1'b1;
            end

            faults_next = sat_inc32(faults_reg);
            begun_next = 1'b1;
            if (elapsed >= {16'd0, win_len_reg})
            begin
                start_next = item_reg.now_ms;
                wf_next = '0;
            end
            else
            begin
                start_next = start_eff;
                wf_next = wf_inc;
                if (wf_inc > {1'b0, budget_reg})
                begin
                    trip = 1'b1;
                    emu_next = 1'b0;
                    depth_next = '0;
                end
            end
        end

        out_next.budget_tripped = trip;
        out_next.interrupts_disabled = (depth_next != '0);
        out_next.emulation_on = emu_next;
        out_next.depth_now = depth_field(depth_next);
        out_next.leak_total = leaks_next;
        out_next.fault_total = faults_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && issue)
        begin
            rd_addr_reg <= site_addr_mem[idx_reg[SLOT_W-1:0]];
            rd_hits_reg <= site_hits_mem[idx_reg[SLOT_W-1:0]];
        end
        if (cmd.commit && wr_en)
        begin
            site_hits_mem[wr_slot] <= wr_hits;
            if (wr_addr_en)
            begin
                site_addr_mem[wr_slot] <= item_reg.site_address;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan && match)
        begin
            hit_slot_reg <= pend_idx_reg;
            hit_cnt_reg <= rd_hits_reg;
        end
        if (cmd.scan)
        begin
            pend_idx_reg <= idx_reg[SLOT_W-1:0];
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= FAULT_BUDGET_RESET;
            win_len_reg <= WINDOW_LENGTH_RESET;
            fill_reg <= '0;
            idx_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            depth_reg <= '0;
            emu_reg <= 1'b1;
            begun_reg <= 1'b0;
            start_reg <= '0;
            wf_reg <= '0;
            faults_reg <= '0;
            leaks_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAULT_BUDGET:  budget_reg <= cfg_wdata;
                    CFG_WINDOW_LENGTH: win_len_reg <= cfg_wdata;
                    default:           ;
                endcase
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
                pend_reg <= 1'b0;
                hit_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                pend_reg <= issue && !match;
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (cmd.commit)
            begin
                fill_reg <= fill_next;
                depth_reg <= depth_next;
                emu_reg <= emu_next;
                begun_reg <= begun_next;
                start_reg <= start_next;
                wf_reg <= wf_next;
                faults_reg <= faults_next;
                leaks_reg <= leaks_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irq_disable_depth_tracker.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data (idt_in_t)
// out       output     out_valid / out_ready   out_data (idt_out_t)
// cfg       input      cfg_we                  cfg_index, cfg_wdata
//
// A trap reads site slots until a match is found (at most the number of claimed
// slots, 32). The site table memory is read one slot per cycle during that scan.
// A resync, or a trap seen with emulation off, skips the scan. Reset leaves the
// site table empty, so it needs no clearing pass. A result waits in the output
// register while out_ready is low; the next input transfer is still taken, and
// its update holds until that result leaves.

module irq_disable_depth_tracker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire idt_pkg::idt_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output idt_pkg::idt_out_t                     out_data,
    input  wire logic                             cfg_we,
    input  wire logic [idt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [idt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import idt_pkg::*;

    idt_cmd_t    cmd;
    idt_status_t status;

    idt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    idt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire
